// ----- design/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and codes of the i2c master transfer sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int FIFO_DEPTH_DEF = 16;

    // function codes of an input beat
    localparam logic [2:0] FN_PUSH  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_EVENT = 3'd2;
    localparam logic [2:0] FN_POP   = 3'd3;
    localparam logic [2:0] FN_ERROR = 3'd4;

    // transfer phase
    localparam logic [1:0] PH_WRITE   = 2'd0;
    localparam logic [1:0] PH_POINTER = 2'd1;
    localparam logic [1:0] PH_DATA    = 2'd2;

    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    localparam logic [1:0] IRQ_NONE = 2'd0;
    localparam logic [1:0] IRQ_EN   = 2'd1;
    localparam logic [1:0] IRQ_DIS  = 2'd2;

    localparam logic [7:0] READ_BIT = 8'h01;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } t_fifo_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- design/i2c_master_transfer_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Master-side sequencer for I2C register writes and reads. Each input beat
// (byte push, start, bus event, byte pop, error) gives exactly one result
// beat with send, start/stop, ack and interrupt control and the port status.
// Bytes sit in a FIFO_DEPTH-entry memory with a registered read; the read
// happens as the beat is accepted and lands with the result, so a beat is
// accepted every cycle while not stalled and its result appears in the next
// cycle. The input stalls only while a result is held by a stalled output.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer #(
    parameter int FIFO_DEPTH = i2cms_pkg::FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_dev_addr,
    input  logic       i_xfer_mode,
    input  logic [7:0] i_xfer_len,
    input  logic [7:0] i_data_byte,
    input  logic       i_ev_start_sent,
    input  logic       i_ev_addr_acked,
    input  logic       i_ev_byte_done,
    input  logic       i_ev_rx_full,
    input  logic       i_ev_tx_empty,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_send_valid,
    output logic [7:0] o_send_byte,
    output logic       o_start_req,
    output logic       o_stop_req,
    output logic [1:0] o_ack_ctrl,
    output logic [1:0] o_buf_irq_ctrl,
    output logic       o_port_status,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte,
    output logic       o_fifo_fault
);
    import i2cms_pkg::*;

    logic       r_out_valid;
    logic       accept;
    logic       advance;
    t_fifo_req  fifo_req;
    t_fifo_stat fifo_stat;
    logic [7:0] fifo_rd_data;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign advance     = !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_in_valid;
        end
    end

    i2cms_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (fifo_req),
        .o_stat    (fifo_stat),
        .o_rd_data (fifo_rd_data)
    );

    i2cms_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_advance       (advance),
        .i_func          (i_func),
        .i_dev_addr      (i_dev_addr),
        .i_xfer_mode     (i_xfer_mode),
        .i_xfer_len      (i_xfer_len),
        .i_data_byte     (i_data_byte),
        .i_ev_start_sent (i_ev_start_sent),
        .i_ev_addr_acked (i_ev_addr_acked),
        .i_ev_byte_done  (i_ev_byte_done),
        .i_ev_rx_full    (i_ev_rx_full),
        .i_ev_tx_empty   (i_ev_tx_empty),
        .i_rx_byte       (i_rx_byte),
        .i_fifo_stat     (fifo_stat),
        .i_fifo_rd_data  (fifo_rd_data),
        .o_fifo_req      (fifo_req),
        .o_send_valid    (o_send_valid),
        .o_send_byte     (o_send_byte),
        .o_start_req     (o_start_req),
        .o_stop_req      (o_stop_req),
        .o_ack_ctrl      (o_ack_ctrl),
        .o_buf_irq_ctrl  (o_buf_irq_ctrl),
        .o_port_status   (o_port_status),
        .o_read_valid    (o_read_valid),
        .o_read_byte     (o_read_byte),
        .o_fifo_fault    (o_fifo_fault)
    );

endmodule

// ----- design/i2cms_fifo.sv -----
// ----------------------------------------------------------------------------
// i2cms_fifo
// byte fifo: one synchronous memory, write at tail, registered read at head
// ----------------------------------------------------------------------------
module i2cms_fifo #(
    parameter int FIFO_DEPTH = i2cms_pkg::FIFO_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  i2cms_pkg::t_fifo_req   i_req,
    output i2cms_pkg::t_fifo_stat  o_stat,
    output logic [7:0]             o_rd_data
);
    import i2cms_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [7:0]    r_mem [FIFO_DEPTH];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_head;
    logic [PW-1:0] n_tail;
    logic [CW-1:0] n_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] idx);
        return (idx == PW'(FIFO_DEPTH - 1)) ? '0 : idx + PW'(1);
    endfunction

    assign o_stat.full  = (r_count == CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rd_data    = r_rd_data;

    always_comb begin
        n_head  = i_req.pop  ? wrap_inc(r_head) : r_head;
        n_tail  = i_req.push ? wrap_inc(r_tail) : r_tail;
        n_count = r_count;
        if (i_req.push && !i_req.pop) begin
            n_count = r_count + CW'(1);
        end else if (i_req.pop && !i_req.push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_tail] <= i_req.wdata;
        end
        if (i_req.pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

endmodule

// ----- design/i2cms_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2cms_ctrl
// transfer state, bus event decode and the result stage
// ----------------------------------------------------------------------------
module i2cms_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_advance,
    input  logic [2:0]            i_func,
    input  logic [7:0]            i_dev_addr,
    input  logic                  i_xfer_mode,
    input  logic [7:0]            i_xfer_len,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_ev_start_sent,
    input  logic                  i_ev_addr_acked,
    input  logic                  i_ev_byte_done,
    input  logic                  i_ev_rx_full,
    input  logic                  i_ev_tx_empty,
    input  logic [7:0]            i_rx_byte,
    input  i2cms_pkg::t_fifo_stat i_fifo_stat,
    input  logic [7:0]            i_fifo_rd_data,
    output i2cms_pkg::t_fifo_req  o_fifo_req,
    output logic                  o_send_valid,
    output logic [7:0]            o_send_byte,
    output logic                  o_start_req,
    output logic                  o_stop_req,
    output logic [1:0]            o_ack_ctrl,
    output logic [1:0]            o_buf_irq_ctrl,
    output logic                  o_port_status,
    output logic                  o_read_valid,
    output logic [7:0]            o_read_byte,
    output logic                  o_fifo_fault
);
    import i2cms_pkg::*;

    logic [1:0] r_phase;
    logic [7:0] r_remaining;
    logic       r_busy;
    logic [7:0] r_target;
    logic [1:0] n_phase;
    logic [7:0] n_remaining;
    logic       n_busy;
    logic [7:0] n_target;

    // result stage
    logic       r_send_lit_v;
    logic       r_send_mem;
    logic [7:0] r_send_lit;
    logic       r_start;
    logic       r_stop;
    logic [1:0] r_ack;
    logic [1:0] r_irq;
    logic       r_status;
    logic       r_read_v;
    logic       r_fault;

    logic       n_send_lit_v;
    logic [7:0] n_send_lit;
    logic       n_start;
    logic       n_stop;
    logic [1:0] n_ack;
    logic [1:0] n_irq;
    logic       want_push;
    logic       want_pop;
    logic [7:0] push_data;
    logic       pop_ok;
    logic       push_ok;

    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_busy       = r_busy;
        n_target     = r_target;
        n_send_lit_v = 1'b0;
        n_send_lit   = '0;
        n_start      = 1'b0;
        n_stop       = 1'b0;
        n_ack        = ACK_NONE;
        n_irq        = IRQ_NONE;
        want_push    = 1'b0;
        want_pop     = 1'b0;
        push_data    = i_data_byte;
        unique case (i_func)
            FN_PUSH: begin
                want_push = 1'b1;
            end
            FN_START: begin
                if (!r_busy) begin
                    n_target    = i_dev_addr;
                    n_phase     = i_xfer_mode ? PH_POINTER : PH_WRITE;
                    n_remaining = i_xfer_len;
                    n_busy      = 1'b1;
                    n_irq       = IRQ_EN;
                    n_ack       = (i_xfer_len > 8'd1) ? ACK_ACK : ACK_NACK;
                    n_start     = 1'b1;
                end
            end
            FN_EVENT: begin
                if (i_ev_start_sent) begin
                    n_send_lit_v = 1'b1;
                    n_send_lit   = (r_phase == PH_DATA) ? (r_target | READ_BIT) : r_target;
                end else if (i_ev_addr_acked) begin
                    if (r_phase == PH_WRITE) begin
                        want_pop = 1'b1;
                        if (r_remaining == '0) begin
                            n_stop = 1'b1;
                            n_busy = 1'b0;
                        end
                    end else if (r_phase == PH_DATA) begin
                        if (r_remaining == 8'd1) begin
                            n_irq  = IRQ_EN;
                            n_stop = 1'b1;
                        end
                    end else if (r_phase == PH_POINTER) begin
                        // register byte goes out, then a repeated start
                        want_pop = 1'b1;
                        n_start  = 1'b1;
                    end
                end else if (i_ev_byte_done) begin
                    if (r_phase == PH_WRITE && r_remaining == '0) begin
                        n_busy = 1'b0;
                    end else if (r_phase == PH_POINTER) begin
                        n_phase = PH_DATA;
                    end
                end else if (i_ev_rx_full && r_phase == PH_DATA) begin
                    if (r_remaining == 8'd1) begin
                        n_irq  = IRQ_DIS;
                        n_busy = 1'b0;
                    end else if (r_remaining == 8'd2) begin
                        n_ack  = ACK_NACK;
                        n_stop = 1'b1;
                    end
                    want_push = 1'b1;
                    push_data = i_rx_byte;
                    if (r_remaining != '0) begin
                        n_remaining = r_remaining - 8'd1;
                    end
                end else if (i_ev_tx_empty && r_phase == PH_WRITE) begin
                    if (r_remaining == '0) begin
                        n_irq  = IRQ_DIS;
                        n_stop = 1'b1;
                    end else begin
                        n_remaining = r_remaining - 8'd1;
                        want_pop    = 1'b1;
                    end
                end
            end
            FN_POP: begin
                want_pop = 1'b1;
            end
            FN_ERROR: begin
                n_stop = 1'b1;
                n_busy = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign pop_ok  = want_pop && !i_fifo_stat.empty;
    assign push_ok = want_push && !i_fifo_stat.full;

    assign o_fifo_req.push  = i_accept && push_ok;
    assign o_fifo_req.pop   = i_accept && pop_ok;
    assign o_fifo_req.wdata = push_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WRITE;
            r_remaining <= '0;
            r_busy      <= 1'b0;
            r_target    <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_busy      <= n_busy;
            r_target    <= n_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_send_lit_v <= n_send_lit_v;
            r_send_mem   <= pop_ok && (i_func != FN_POP);
            r_send_lit   <= n_send_lit;
            r_start      <= n_start;
            r_stop       <= n_stop;
            r_ack        <= n_ack;
            r_irq        <= n_irq;
            r_status     <= n_busy;
            r_read_v     <= pop_ok && (i_func == FN_POP);
            r_fault      <= (want_pop && !pop_ok) || (want_push && !push_ok);
        end
    end

    // popped byte arrives from the memory read register with the result
    assign o_send_valid   = r_send_lit_v || r_send_mem;
    assign o_send_byte    = r_send_mem ? i_fifo_rd_data : r_send_lit;
    assign o_start_req    = r_start;
    assign o_stop_req     = r_stop;
    assign o_ack_ctrl     = r_ack;
    assign o_buf_irq_ctrl = r_irq;
    assign o_port_status  = r_status;
    assign o_read_valid   = r_read_v;
    assign o_read_byte    = r_read_v ? i_fifo_rd_data : 8'd0;
    assign o_fifo_fault   = r_fault;

endmodule
